FILE: design/stis_pkg.sv
// ----------------------------------------------------------------------------
// stis_pkg: shared types and constants of the sorted table
// Field widths, operation and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package stis_pkg;

	localparam int DEF_CAPACITY = 16;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;

	// Operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

	// Per-cell update control
	typedef struct packed {
		logic load_key;  // take the new value
		logic shift;     // take the left neighbor's value
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/stis_cell.sv
// ----------------------------------------------------------------------------
// stis_cell: one slot of the sorted table
// Holds one value, compares it against the key, and on an insert either
// keeps it, takes the key, or takes the value of the slot to its left.
// ----------------------------------------------------------------------------
`default_nettype none

module stis_cell (
	input  wire                                 clk,
	input  wire  signed [stis_pkg::VALUE_W-1:0] key,
	input  wire                                 occupied,
	input  stis_pkg::cell_ctl_t                 ctl,
	input  wire  signed [stis_pkg::VALUE_W-1:0] left_val,
	output logic signed [stis_pkg::VALUE_W-1:0] val,
	output logic                                less,
	output logic                                eq
);

	logic signed [stis_pkg::VALUE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.load_key) begin
			val_q <= key;
		end else if (ctl.shift) begin
			val_q <= left_val;
		end
	end

	assign val  = val_q;
	assign less = occupied && (val_q < key);
	assign eq   = occupied && (val_q == key);

endmodule

`default_nettype wire

FILE: design/sorted_table_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search: ordered table with insert and search
// A row of CAPACITY cells keeps signed values in ascending order. Insert
// places a value before the first stored value that is not smaller; search
// reports the index of the first match.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  request  | start / busy       | func, value
//  result   | done (one strobe)  | status, position, entry_count
//
//  Each request passes in order from transfer to the done strobe through s1,
//  where every cell compares its value with the key, then s2, where the compare
//  vector is encoded and the cells shift, then the result registers on the ports.
//  busy is high while a request is in s1 or s2; a new request can be
//  taken in the cycle done is high, so requests never overlap.
//  Reset clears the fill count and the stage flags; cell contents are not
//  cleared, only the first entry_count cells are ever looked at.
//  The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_search #(
	parameter int CAPACITY = stis_pkg::DEF_CAPACITY
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire                                 func,
	input  wire  signed [stis_pkg::VALUE_W-1:0] value,
	output logic                                done,
	output logic        [stis_pkg::STATUS_W-1:0] status,
	output logic        [stis_pkg::POS_W-1:0]    position,
	output logic        [stis_pkg::CNT_W-1:0]    entry_count
);

	localparam int IW = $clog2(CAPACITY);        // cell index width
	localparam int CW = $clog2(CAPACITY + 1);    // fill count width
	localparam int PW = (IW > stis_pkg::POS_W) ? IW : stis_pkg::POS_W;
	localparam int NW = (CW > stis_pkg::CNT_W) ? CW : stis_pkg::CNT_W;

	// Request registers, held while busy
	logic                                 func_q;
	logic signed [stis_pkg::VALUE_W-1:0]  key_q;
	logic                                 s1_vld_q;
	logic                                 s2_vld_q;
	logic [CW-1:0]                        fill_q;

	// Compare vectors
	logic [CAPACITY-1:0] less_c, eq_c;
	logic [CAPACITY-1:0] less_s2, eq_s2;

	logic signed [stis_pkg::VALUE_W-1:0] cell_val [CAPACITY];
	stis_pkg::cell_ctl_t                 cell_ctl [CAPACITY];

	logic accept;
	assign busy   = s1_vld_q | s2_vld_q;
	assign accept = start & ~busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= accept;
			s2_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld_q) begin
			less_s2 <= less_c;
			eq_s2   <= eq_c;
		end
	end

	// Insert goes ahead only when there is room
	logic full, ins_go;
	assign full   = (fill_q == CW'(CAPACITY));
	assign ins_go = s2_vld_q && (func_q == stis_pkg::FUNC_INSERT) && !full;

	// Cell row. less is a thermometer: ones for the cells below the key.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic prev_less;
			logic signed [stis_pkg::VALUE_W-1:0] left;

			if (gi == 0) begin : g_head
				assign prev_less = 1'b1;
				assign left      = key_q;
			end else begin : g_body
				assign prev_less = less_s2[gi-1];
				assign left      = cell_val[gi-1];
			end

			// {load_key, shift}
			assign cell_ctl[gi] = {ins_go & prev_less & ~less_s2[gi],
				ins_go & ~prev_less};

			stis_cell u_cell (
				.clk      (clk),
				.key      (key_q),
				.occupied (CW'(gi) < fill_q),
				.ctl      (cell_ctl[gi]),
				.left_val (left),
				.val      (cell_val[gi]),
				.less     (less_c[gi]),
				.eq       (eq_c[gi])
			);
		end
	endgenerate

	// Boundary of the thermometer: the first cell not below the key
	logic [CAPACITY-1:0] edge_oh;
	logic [IW-1:0]       idx;
	logic                found;

	assign edge_oh = {less_s2[CAPACITY-2:0], 1'b1} & ~less_s2;

	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (edge_oh[i]) begin
				idx = idx | IW'(i);
			end
			found = found | (edge_oh[i] & eq_s2[i]);
		end
	end

	// Fill count
	logic [CW-1:0] fill_nxt;
	assign fill_nxt = ins_go ? (fill_q + CW'(1)) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nxt;
		end
	end

	// Result
	logic [stis_pkg::STATUS_W-1:0] status_c;
	logic [PW-1:0]                 pos_c;
	logic [NW-1:0]                 cnt_c;

	always_comb begin
		status_c = stis_pkg::ST_OK;
		pos_c    = PW'(idx);
		if (func_q == stis_pkg::FUNC_INSERT) begin
			if (full) begin
				status_c = stis_pkg::ST_FULL;
				pos_c    = '0;
			end
		end else if (!found) begin
			status_c = stis_pkg::ST_MISS;
			pos_c    = '0;
		end
		cnt_c = NW'(fill_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= s2_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_vld_q) begin
			status      <= status_c;
			position    <= pos_c[stis_pkg::POS_W-1:0];
			entry_count <= cnt_c[stis_pkg::CNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: test/stis_checker.sv
// ----------------------------------------------------------------------------
// stis_checker: result checker for the sorted table
// Watches request and result transfers, keeps its own ordered table and
// compares every done strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stis_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire                                 busy,
	input  wire                                 func,
	input  wire signed [stis_pkg::VALUE_W-1:0]  value,
	input  wire                                 done,
	input  wire        [stis_pkg::STATUS_W-1:0] status,
	input  wire        [stis_pkg::POS_W-1:0]    position,
	input  wire        [stis_pkg::CNT_W-1:0]    entry_count,
	output int                                  err_count,
	output int                                  outstanding
);

	localparam int CAPACITY = stis_pkg::DEF_CAPACITY;

	typedef struct packed {
		logic [stis_pkg::STATUS_W-1:0] status;
		logic [stis_pkg::POS_W-1:0]    position;
		logic [stis_pkg::CNT_W-1:0]    entry_count;
	} table_result_t;

	logic signed [stis_pkg::VALUE_W-1:0] sorted_vals [CAPACITY];
	int                                  fill;
	table_result_t                       pending_results [$];

	always @(posedge clk or negedge arst_n) begin : watch
		table_result_t want;
		int            idx;
		if (!arst_n) begin
			fill = 0;
			err_count = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// result side: one strobe, one result
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: status %0d position %0d entry_count %0d",
						status, position, entry_count);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_count++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						err_count++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, entry_count);
						err_count++;
					end
				end
			end

			// request side: predict on every accepted transfer
			if (start && !busy) begin
				want = '{status: stis_pkg::ST_OK, position: '0, entry_count: '0};
				idx = 0;
				while (idx < fill && sorted_vals[idx] < value)
					idx++;
				if (func == stis_pkg::FUNC_INSERT) begin
					if (fill >= CAPACITY) begin
						want.status = stis_pkg::ST_FULL;
					end else begin
						for (int j = fill; j > idx; j--)
							sorted_vals[j] = sorted_vals[j-1];
						sorted_vals[idx] = value;
						fill++;
						want.position = idx[stis_pkg::POS_W-1:0];
					end
				end else if (idx < fill && sorted_vals[idx] == value) begin
					want.position = idx[stis_pkg::POS_W-1:0];
				end else begin
					want.status = stis_pkg::ST_MISS;
				end
				want.entry_count = fill[stis_pkg::CNT_W-1:0];
				pending_results.push_back(want);
			end

			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: test/sorted_table_insert_search_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search_tb: top of the sorted table testbench
// Drives insert and search requests with random gaps; the checker beside the
// block predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_table_insert_search_tb;

	localparam logic signed [stis_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [stis_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 500;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 func;
	logic signed [stis_pkg::VALUE_W-1:0]  value;
	wire                                  busy;
	wire                                  done;
	wire         [stis_pkg::STATUS_W-1:0] status;
	wire         [stis_pkg::POS_W-1:0]    position;
	wire         [stis_pkg::CNT_W-1:0]    entry_count;
	int                                   err_count;
	int                                   outstanding;

	// values that made it into the table; used to aim searches at hits and near misses and to pick duplicates
	logic signed [stis_pkg::VALUE_W-1:0]  stored_keys [$];
	// length of the current back-to-back stretch (no gaps between requests)
	int                                   burst_left;

	sorted_table_insert_search u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.value       (value),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	stis_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.value       (value),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_count (entry_count),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// One request transfer. Called at a rising edge; returns at the edge
	// where the transfer happened. start is only lowered when a gap follows,
	// so back-to-back requests never see a low/high pair in one time step.
	task automatic send_request(input logic f,
		input logic signed [stis_pkg::VALUE_W-1:0] v);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 12);
			if ($urandom_range(0, 19) == 0)
				burst_left = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			// idle: payload wiggles, start low, nothing must be taken
			start <= 1'b0;
			func  <= 1'($urandom_range(0, 1));
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func  <= f;
		value <= v;
		// busy sampled at the edge is the value before it: low means taken
		do
			@(posedge clk);
		while (busy);
		if (f == stis_pkg::FUNC_INSERT && stored_keys.size() < stis_pkg::DEF_CAPACITY)
			stored_keys.push_back(v);
	endtask

	initial begin : stimulus
		int pick;
		logic signed [stis_pkg::VALUE_W-1:0] v;
		arst_n     = 1'b0;
		start      = 1'b0;
		func       = stis_pkg::FUNC_INSERT;
		value      = '0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_request(stis_pkg::FUNC_SEARCH, 0);           // search on an empty table
		send_request(stis_pkg::FUNC_INSERT, 0);           // into empty table
		send_request(stis_pkg::FUNC_INSERT, 0);           // duplicate goes before the equal entry
		send_request(stis_pkg::FUNC_INSERT, VAL_MAX);     // tail
		send_request(stis_pkg::FUNC_INSERT, VAL_MIN);     // head insert, shifts everything
		send_request(stis_pkg::FUNC_INSERT, -1);          // middle
		send_request(stis_pkg::FUNC_SEARCH, 0);           // first of the duplicates
		send_request(stis_pkg::FUNC_SEARCH, VAL_MAX);
		send_request(stis_pkg::FUNC_SEARCH, VAL_MIN);
		send_request(stis_pkg::FUNC_SEARCH, -2);          // miss between two entries
		send_request(stis_pkg::FUNC_SEARCH, 1);           // miss just above the zeros
		send_request(stis_pkg::FUNC_SEARCH, VAL_MAX - 1); // miss below the top entry
		// fill up to capacity with a mix of fresh values and duplicates
		for (int k = 0; k < 11; k++) begin
			if (k % 3 == 0)
				v = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			else
				v = $urandom;
			send_request(stis_pkg::FUNC_INSERT, v);
		end
		send_request(stis_pkg::FUNC_INSERT, 5);           // table full: dropped
		send_request(stis_pkg::FUNC_INSERT, VAL_MIN);     // full, would have been the head
		send_request(stis_pkg::FUNC_SEARCH, stored_keys[stored_keys.size() - 1]);

		// --- random part: table is full, so mostly lookups ---
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// hit on a stored value
				send_request(stis_pkg::FUNC_SEARCH,
					stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
			end else if (pick < 65) begin
				// neighbor of a stored value, usually a miss
				v = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
				send_request(stis_pkg::FUNC_SEARCH,
					$urandom_range(0, 1) ? v + 1 : v - 1);
			end else if (pick < 80) begin
				send_request(stis_pkg::FUNC_SEARCH, $urandom);
			end else if (pick < 90) begin
				case ($urandom_range(0, 3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = 0;
					default: v = -1;
				endcase
				send_request(stis_pkg::FUNC_SEARCH, v);
			end else begin
				send_request(stis_pkg::FUNC_INSERT, $urandom);
			end
		end
		start <= 1'b0;

		// drain: every predicted result must show up, then a few quiet cycles
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
